>>> sv/lnf_pkg.sv
// Package for the letter n-gram frequency counter.
// Holds the shared constants, command codes and structs; no dependencies.
package lnf_pkg;
    localparam int MAX_GROUP_LETTERS = 4;
    localparam int TABLE_ENTRIES = 256;
    localparam int ADDR_W = 8;
    localparam int USED_W = 9;
    localparam int KEY_W = 32;
    localparam int COUNT_W = 16;
    localparam int LEN_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [7:0] PAD_LETTER = 8'h3F;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Input word kinds, carried on tuser.
    localparam logic [1:0] FUNC_TEXT = 2'd0;
    localparam logic [1:0] FUNC_END = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    // Commands passed from the front end to the table engine.
    localparam logic [1:0] CMD_GROUP = 2'd0;
    localparam logic [1:0] CMD_END = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic              has_group;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic              full;
        logic [15:0]       total;
        logic [USED_W-1:0] distinct;
        logic              present;
        logic [15:0]       count;
        logic [31:0]       text;
    } t_result;
endpackage

>>> sv/lnf_front.sv
// Front end: filters and uppercases letters, packs groups, turns words into commands.
// Depends on lnf_pkg.
module lnf_front
    import lnf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_char,
    input  logic [7:0]       i_idx,
    input  logic             i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);
    logic [LEN_W-1:0] r_len, n_len;
    logic [KEY_W-1:0] r_partial, n_partial;
    logic [LEN_W-1:0] r_fill, n_fill;

    logic [7:0]       c_up;
    logic             is_letter;
    logic [KEY_W-1:0] key_add;
    logic [KEY_W-1:0] key_pad;
    logic [LEN_W-1:0] fill_inc;
    logic             accept;

    // No word is taken in a cycle that writes the group length.
    assign o_ready = !i_q_full && !i_cfg_wr_en;
    assign accept = i_valid && o_ready;
    assign c_up = (i_char >= 8'h61 && i_char <= 8'h7A) ? i_char - 8'h20 : i_char;
    assign is_letter = (c_up >= 8'h41 && c_up <= 8'h5A);
    assign key_add = r_partial | ({24'd0, c_up} << {r_fill, 3'b000});
    assign fill_inc = r_fill + LEN_W'(1);

    always_comb begin
        for (int j = 0; j < MAX_GROUP_LETTERS; j++) begin
            if (LEN_W'(j) < r_fill) begin
                key_pad[8*j +: 8] = r_partial[8*j +: 8];
            end else if (LEN_W'(j) < r_len) begin
                key_pad[8*j +: 8] = PAD_LETTER;
            end else begin
                key_pad[8*j +: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        n_len = r_len;
        n_partial = r_partial;
        n_fill = r_fill;
        o_push = 1'b0;
        o_cmd.op = CMD_GROUP;
        o_cmd.has_group = 1'b0;
        o_cmd.key = key_add;
        o_cmd.idx = i_idx;
        if (i_cfg_wr_en) begin
            if (i_cfg_wr_data == '0) begin
                n_len = LEN_W'(1);
            end else if (i_cfg_wr_data > LEN_W'(MAX_GROUP_LETTERS)) begin
                n_len = LEN_W'(MAX_GROUP_LETTERS);
            end else begin
                n_len = i_cfg_wr_data;
            end
            n_partial = '0;
            n_fill = '0;
        end else if (accept) begin
            case (i_func)
                FUNC_TEXT: begin
                    if (is_letter) begin
                        if (fill_inc >= r_len) begin
                            o_push = 1'b1;
                            o_cmd.has_group = 1'b1;
                            n_partial = '0;
                            n_fill = '0;
                        end else begin
                            n_partial = key_add;
                            n_fill = fill_inc;
                        end
                    end
                end
                FUNC_END: begin
                    o_push = 1'b1;
                    o_cmd.op = CMD_END;
                    o_cmd.has_group = (r_fill != '0);
                    o_cmd.key = key_pad;
                    n_partial = '0;
                    n_fill = '0;
                end
                FUNC_READ: begin
                    o_push = 1'b1;
                    o_cmd.op = CMD_READ;
                end
                default: begin
                    o_push = 1'b1;
                    o_cmd.op = CMD_CLEAR;
                    n_partial = '0;
                    n_fill = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
            r_partial <= '0;
            r_fill <= '0;
        end else begin
            r_len <= n_len;
            r_partial <= n_partial;
            r_fill <= n_fill;
        end
    end
endmodule

>>> sv/lnf_queue.sv
// Short command queue between the front end and the table engine.
// Depends on lnf_pkg.
module lnf_queue
    import lnf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);
    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end
endmodule

>>> sv/lnf_back.sv
// Table engine: searches the group table, updates counts and forms result words.
// Depends on lnf_pkg.
module lnf_back
    import lnf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CMP = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [KEY_W+COUNT_W-1:0] r_table [TABLE_ENTRIES];
    logic [KEY_W+COUNT_W-1:0] r_rdata;

    logic [2:0]         r_state;
    t_cmd               r_cmd;
    logic [ADDR_W-1:0]  r_idx;
    logic [USED_W-1:0]  r_used;
    logic [COUNT_W-1:0] r_total;
    logic               r_full;
    logic [KEY_W-1:0]   r_text;
    logic [COUNT_W-1:0] r_count;
    logic               r_present;
    logic               r_out_valid;
    t_result            r_out;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [KEY_W+COUNT_W-1:0] wdata;
    logic [COUNT_W-1:0]       cnt_rd;
    logic                     key_hit;
    logic                     last_entry;
    logic                     out_free;

    assign cnt_rd = r_rdata[COUNT_W-1:0];
    assign key_hit = (r_rdata[KEY_W+COUNT_W-1:COUNT_W] == r_cmd.key);
    assign last_entry = ({1'b0, r_idx} + USED_W'(1)) == r_used;
    assign out_free = !r_out_valid || i_ready;
    assign o_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        we = 1'b0;
        waddr = r_idx;
        wdata = {r_cmd.key, COUNT_W'(1)};
        if (r_state == S_CMP && r_cmd.op != CMD_READ && key_hit) begin
            we = 1'b1;
            wdata = {r_cmd.key, (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_W'(1)};
        end else if (r_state == S_APPEND && r_used < USED_W'(TABLE_ENTRIES)) begin
            we = 1'b1;
            waddr = r_used[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_table[waddr] <= wdata;
        end
        r_rdata <= r_table[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_total <= '0;
            r_full <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_text <= '0;
                        r_count <= '0;
                        r_present <= 1'b0;
                        if (i_cmd.op == CMD_CLEAR) begin
                            r_used <= '0;
                            r_total <= '0;
                            r_full <= 1'b0;
                        end else if (i_cmd.op == CMD_READ) begin
                            r_idx <= i_cmd.idx;
                            r_state <= ({1'b0, i_cmd.idx} < r_used) ? S_READ : S_OUT;
                        end else if (i_cmd.op == CMD_END && !i_cmd.has_group) begin
                            r_state <= S_OUT;
                        end else begin
                            if (r_total != COUNT_MAX) begin
                                r_total <= r_total + COUNT_W'(1);
                            end
                            r_state <= (r_used == '0) ? S_APPEND : S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_cmd.op == CMD_READ) begin
                        r_text <= r_rdata[KEY_W+COUNT_W-1:COUNT_W];
                        r_count <= cnt_rd;
                        r_present <= 1'b1;
                        r_state <= S_OUT;
                    end else if (key_hit) begin
                        r_state <= (r_cmd.op == CMD_END) ? S_OUT : S_IDLE;
                    end else if (last_entry) begin
                        r_state <= S_APPEND;
                    end else begin
                        r_idx <= r_idx + ADDR_W'(1);
                        r_state <= S_READ;
                    end
                end
                S_APPEND: begin
                    if (r_used < USED_W'(TABLE_ENTRIES)) begin
                        r_used <= r_used + USED_W'(1);
                    end else begin
                        r_full <= 1'b1;
                    end
                    r_state <= (r_cmd.op == CMD_END) ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.text <= r_text;
                        r_out.count <= r_count;
                        r_out.present <= r_present;
                        r_out.distinct <= r_used;
                        r_out.total <= r_total;
                        r_out.full <= r_full;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> sv/letter_ngram_frequency_counter_top.sv
// Top level of the letter n-gram frequency counter.
// Depends on lnf_pkg, lnf_front, lnf_queue and lnf_back.

// Counts uppercased letter groups of 1 to 4 letters in a byte stream and keeps them in a
// 256-entry table in first-seen order. A text word is taken while the four-deep command
// queue has room; s_axis_tready is low in a cycle that writes the group length. A completed
// group is searched one table entry at a time, each entry read through the table's
// registered read port and then compared; if none matches it is appended while there is room.
// Read and end-of-text words produce one result word each, held in an output register until
// taken.
module letter_ngram_frequency_counter_top
    import lnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,   // group_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // char_code[7:0], entry_index[15:8]
    input  logic [1:0]  s_axis_tuser,    // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // group_text[31:0], group_count[47:32], entry_present[48], distinct_groups[57:49],
    // total_groups[73:58], table_full[74], zero fill [79:75]
    output logic [79:0] m_axis_tdata
);
    t_cmd    push_cmd, q_cmd;
    logic    push, q_full, q_empty, pop;
    t_result res;

    lnf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_func        (s_axis_tuser),
        .i_char        (s_axis_tdata[7:0]),
        .i_idx         (s_axis_tdata[15:8]),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lnf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (res)
    );

    assign m_axis_tdata = {5'd0, res};
endmodule

>>> sv/lnf_checker.sv
// Port-level checker for the letter n-gram frequency counter, bound to the top level.
// Depends on letter_ngram_frequency_counter_top.
module lnf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    // A stalled result word holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A missing entry reads back as empty text and zero count.
    a_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[47:0] == 48'd0)
        else $error("absent entry carries data");

    // The table never holds more than 256 entries, nor more entries than groups counted.
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[57:49] <= 9'd256
            && {7'd0, m_axis_tdata[57:49]} <= m_axis_tdata[73:58])
        else $error("entry count out of range");
endmodule

bind letter_ngram_frequency_counter_top lnf_checker u_lnf_checker (.*);
